/* rtl/assert_macros.svh */
// assertion helpers used by signed_tetra_volume_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, quiet while reset is applied
`define STV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check, but also evaluated while reset is applied
`define STV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/stv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stv_pkg
// Shared widths and defaults of the signed tetrahedron volume pipeline.
// ----------------------------------------------------------------------------
package stv_pkg;

	localparam int IN_W            = 16;
	localparam int OUT_W           = 52;
	localparam int NUM_COORDS      = 12;
	localparam int NUM_DIFFS       = 9;
	localparam int NUM_PRODS       = 6;
	localparam int NUM_MINORS      = 3;
	localparam int COORD_BITS_DEF  = 16;

endpackage

/* rtl/stv_diff.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stv_diff
// Stage 1: sign-extends the coordinates and forms a-d, b-d, c-d.
// ----------------------------------------------------------------------------
module stv_diff #(
	parameter int COORD_BITS = stv_pkg::COORD_BITS_DEF,
	localparam int D_W = COORD_BITS + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_i,
	output logic                        ready_o,
	input  logic [stv_pkg::IN_W-1:0]    coord [stv_pkg::NUM_COORDS],
	output logic                        valid_o,
	input  logic                        ready_i,
	output logic signed [D_W-1:0]       diff_s1 [stv_pkg::NUM_DIFFS]
);

	logic valid_s1;
	logic signed [D_W-1:0] ext [stv_pkg::NUM_COORDS];

	assign ready_o = !valid_s1 || ready_i;
	assign valid_o = valid_s1;

	// only the low COORD_BITS bits of a field count
	always_comb begin
		for (int i = 0; i < stv_pkg::NUM_COORDS; i++) begin
			ext[i] = $signed({coord[i][COORD_BITS-1], coord[i][COORD_BITS-1:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	// point d sits in coords 9..11
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			for (int i = 0; i < stv_pkg::NUM_DIFFS; i++) begin
				diff_s1[i] <= ext[i] - ext[stv_pkg::NUM_DIFFS + (i % 3)];
			end
		end
	end

endmodule

/* rtl/stv_minor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stv_minor
// Stages 2 and 3: products of the v and w rows, then the three 2x2 minors.
// ----------------------------------------------------------------------------
module stv_minor #(
	parameter int COORD_BITS = stv_pkg::COORD_BITS_DEF,
	localparam int D_W = COORD_BITS + 1,
	localparam int P_W = 2 * D_W,
	localparam int M_W = P_W + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_i,
	output logic                        ready_o,
	input  logic signed [D_W-1:0]       diff [stv_pkg::NUM_DIFFS],
	output logic                        valid_o,
	input  logic                        ready_i,
	output logic signed [D_W-1:0]       u_s3 [3],
	output logic signed [M_W-1:0]       minor_s3 [stv_pkg::NUM_MINORS]
);

	logic valid_s2, valid_s3;
	logic ready_s2, ready_s3;
	logic signed [P_W-1:0] prod_s2 [stv_pkg::NUM_PRODS];
	logic signed [D_W-1:0] u_s2 [3];

	assign ready_s3 = !valid_s3 || ready_i;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_o  = ready_s2;
	assign valid_o  = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_i;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// diff order: ux uy uz vx vy vz wx wy wz
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_i) begin
			prod_s2[0] <= diff[4] * diff[8];
			prod_s2[1] <= diff[5] * diff[7];
			prod_s2[2] <= diff[3] * diff[8];
			prod_s2[3] <= diff[5] * diff[6];
			prod_s2[4] <= diff[3] * diff[7];
			prod_s2[5] <= diff[4] * diff[6];
			for (int i = 0; i < 3; i++) begin
				u_s2[i] <= diff[i];
			end
		end
		if (ready_s3 && valid_s2) begin
			for (int i = 0; i < stv_pkg::NUM_MINORS; i++) begin
				minor_s3[i] <= M_W'(prod_s2[2*i]) - M_W'(prod_s2[2*i+1]);
				u_s3[i]     <= u_s2[i];
			end
		end
	end

endmodule

/* rtl/stv_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stv_accum
// Stages 4 and 5: u times each minor, then the signed sum into the output.
// ----------------------------------------------------------------------------
module stv_accum #(
	parameter int COORD_BITS = stv_pkg::COORD_BITS_DEF,
	localparam int D_W = COORD_BITS + 1,
	localparam int M_W = 2 * D_W + 1,
	localparam int T_W = D_W + M_W,
	localparam int OUT_W = stv_pkg::OUT_W,
	localparam int SUM_W = (T_W + 2 > OUT_W) ? T_W + 2 : OUT_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_i,
	output logic                        ready_o,
	input  logic signed [D_W-1:0]       u [3],
	input  logic signed [M_W-1:0]       minor [stv_pkg::NUM_MINORS],
	output logic                        valid_o,
	input  logic                        ready_i,
	output logic                        valid_s4_o,
	output logic [OUT_W-1:0]            vol_s5
);

	logic valid_s4, valid_s5;
	logic ready_s4, ready_s5;
	logic signed [T_W-1:0] term_s4 [3];

	assign ready_s5   = !valid_s5 || ready_i;
	assign ready_s4   = !valid_s4 || ready_s5;
	assign ready_o    = ready_s4;
	assign valid_o    = valid_s5;
	assign valid_s4_o = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s4) begin
				valid_s4 <= valid_i;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// volume = -(ux*m0 - uy*m1 + uz*m2)
	always_ff @(posedge clk) begin
		if (ready_s4 && valid_i) begin
			for (int i = 0; i < 3; i++) begin
				term_s4[i] <= T_W'(u[i]) * T_W'(minor[i]);
			end
		end
		if (ready_s5 && valid_s4) begin
			vol_s5 <= OUT_W'(SUM_W'(term_s4[1]) - SUM_W'(term_s4[0]) - SUM_W'(term_s4[2]));
		end
	end

endmodule

/* rtl/signed_tetra_volume_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_tetra_volume_unit
// Six times the signed volume of tetrahedron (a, b, c, d), exact integer.
// ----------------------------------------------------------------------------
// Five-stage pipeline: differences, six products, three minors, three
// products with the first row, final sum. One beat is accepted every clock
// while in_stall is low. The multiplier stages set the clock; in_stall
// rises only when the output register is held and every stage behind it
// is full, and bubbles between beats are squeezed out while the output
// waits.
module signed_tetra_volume_unit #(
	parameter int COORD_BITS = stv_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [stv_pkg::IN_W-1:0]    a_x,
	input  logic [stv_pkg::IN_W-1:0]    a_y,
	input  logic [stv_pkg::IN_W-1:0]    a_z,
	input  logic [stv_pkg::IN_W-1:0]    b_x,
	input  logic [stv_pkg::IN_W-1:0]    b_y,
	input  logic [stv_pkg::IN_W-1:0]    b_z,
	input  logic [stv_pkg::IN_W-1:0]    c_x,
	input  logic [stv_pkg::IN_W-1:0]    c_y,
	input  logic [stv_pkg::IN_W-1:0]    c_z,
	input  logic [stv_pkg::IN_W-1:0]    d_x,
	input  logic [stv_pkg::IN_W-1:0]    d_y,
	input  logic [stv_pkg::IN_W-1:0]    d_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [stv_pkg::OUT_W-1:0]   volume_six
);

`include "assert_macros.svh"

	localparam int D_W = COORD_BITS + 1;
	localparam int M_W = 2 * D_W + 1;

	logic [stv_pkg::IN_W-1:0] coord [stv_pkg::NUM_COORDS];
	logic signed [D_W-1:0] diff_s1 [stv_pkg::NUM_DIFFS];
	logic signed [D_W-1:0] u_s3 [3];
	logic signed [M_W-1:0] minor_s3 [stv_pkg::NUM_MINORS];
	logic ready_s1, valid_s1, ready_mid, valid_s3, ready_acc, valid_s4;

	assign coord = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z};
	assign in_stall = !ready_s1;

	stv_diff #(.COORD_BITS(COORD_BITS)) u_diff (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (in_valid),
		.ready_o (ready_s1),
		.coord   (coord),
		.valid_o (valid_s1),
		.ready_i (ready_mid),
		.diff_s1 (diff_s1)
	);

	stv_minor #(.COORD_BITS(COORD_BITS)) u_minor (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (valid_s1),
		.ready_o  (ready_mid),
		.diff     (diff_s1),
		.valid_o  (valid_s3),
		.ready_i  (ready_acc),
		.u_s3     (u_s3),
		.minor_s3 (minor_s3)
	);

	stv_accum #(.COORD_BITS(COORD_BITS)) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_i    (valid_s3),
		.ready_o    (ready_acc),
		.u          (u_s3),
		.minor      (minor_s3),
		.valid_o    (out_valid),
		.ready_i    (!out_stall),
		.valid_s4_o (valid_s4),
		.vol_s5     (volume_six)
	);

	// an empty output register never pushes back on the input
	`STV_ASSERT_ALWAYS(a_no_stall_when_out_empty, !out_valid |-> !in_stall, "input stalled with empty output")
	// a held output must not drop the beat waiting behind it
	`STV_ASSERT(a_s4_kept, (valid_s4 && out_valid && out_stall) |=> valid_s4, "stage 4 beat lost during stall")
	// a beat entering an empty pipe reaches the output
	`STV_ASSERT(a_latency, (in_valid && !in_stall && !valid_s1 && !valid_s3 && !valid_s4 && !out_valid) |-> ##5 out_valid, "beat did not reach output in time")

endmodule
